### rtl/cmm_pkg.sv
// ============================================================================
// cmm_pkg: shared types and constants for the complex matrix multiply block
// Request mode codes, control FSM states, datapath control struct and the
// fixed field widths of the request and response channels.
// ============================================================================
package cmm_pkg;

    // Fixed field widths
    localparam int ROW_W  = 4;
    localparam int SIZE_W = 5;
    localparam int SUM_W  = 37;

    // Matrix dimension after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Request codes
    typedef enum logic [1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_RD   = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the MAC datapath
    typedef struct packed {
        logic vld;   // memory read data valid this cycle
        logic clr;   // clear the accumulators
    } mac_ctrl_t;

endpackage

### rtl/cmm_if.sv
// ============================================================================
// cmm_if: request and response channels of the complex matrix multiply
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface cmm_req_if
    import cmm_pkg::*;
#(
    parameter int ELEM_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [ROW_W-1:0]            row;
    logic [ROW_W-1:0]            col;
    logic signed [ELEM_BITS-1:0] re_in;
    logic signed [ELEM_BITS-1:0] im_in;

    modport source (output valid, mode, row, col, re_in, im_in, input ready);
    modport sink   (input valid, mode, row, col, re_in, im_in, output ready);
endinterface

interface cmm_rsp_if
    import cmm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] re_out;
    logic signed [SUM_W-1:0] im_out;
    logic                    in_range;

    modport source (output valid, re_out, im_out, in_range, input ready);
    modport sink   (input valid, re_out, im_out, in_range, output ready);
endinterface

### rtl/cmm_mac.sv
// ============================================================================
// cmm_mac: complex multiply-accumulate datapath
// One complex product per cycle: four registered real products, then the
// real and imaginary accumulators at full precision.
// ============================================================================
module cmm_mac
    import cmm_pkg::*;
#(
    parameter int ELEM_BITS = 16,
    parameter int MAX_DIM   = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic [2*ELEM_BITS-1:0]     a_elem,
    input  logic [2*ELEM_BITS-1:0]     b_elem,
    output logic                       busy,
    output logic signed [SUM_W-1:0]    sum_re,
    output logic signed [SUM_W-1:0]    sum_im
);

    localparam int PW    = 2 * ELEM_BITS;
    localparam int ACC_W = PW + 2 + $clog2(MAX_DIM);
    localparam int EXT_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;

    logic signed [ELEM_BITS-1:0] ar, ai, br, bi;
    logic signed [PW-1:0]        rr_reg, ii_reg, ri_reg, ir_reg;
    logic                        mul_vld_reg;
    logic signed [EXT_W-1:0]     acc_re_reg, acc_im_reg;
    logic signed [EXT_W-1:0]     acc_re_next, acc_im_next;

    // Element unpacking: real part low, imaginary part high
    assign ar = a_elem[ELEM_BITS-1:0];
    assign ai = a_elem[PW-1:ELEM_BITS];
    assign br = b_elem[ELEM_BITS-1:0];
    assign bi = b_elem[PW-1:ELEM_BITS];

    // Product stage
    always_ff @(posedge clk)
    begin
        rr_reg <= ar * br;
        ii_reg <= ai * bi;
        ri_reg <= ar * bi;
        ir_reg <= ai * br;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= ctrl.vld;
        end
    end

    // Accumulate stage
    always_comb
    begin
        acc_re_next = acc_re_reg
                    + {{(EXT_W-PW){rr_reg[PW-1]}}, rr_reg}
                    - {{(EXT_W-PW){ii_reg[PW-1]}}, ii_reg};
        acc_im_next = acc_im_reg
                    + {{(EXT_W-PW){ri_reg[PW-1]}}, ri_reg}
                    + {{(EXT_W-PW){ir_reg[PW-1]}}, ir_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign busy   = mul_vld_reg;
    assign sum_re = acc_re_reg[SUM_W-1:0];
    assign sum_im = acc_im_reg[SUM_W-1:0];

endmodule

### rtl/complex_matrix_multiply.sv
// Write of an A or B element: no response.
// Product read: ISSUE makes one A and one B memory read per cycle into one MAC for each
// of the n terms (n = size in use), DRAIN lets the MAC finish, EMIT loads the response
// register and the next request can transfer. Out-of-range read: EMIT at once, zero sum.
// One request in progress at a time; the response register lets the next request
// transfer while a response waits. Reset: size 16, control cleared, matrices undefined.
// ============================================================================
// complex_matrix_multiply: element-addressed complex matrix product
// Holds matrices A and B in two synchronous memories and answers a read of
// C(row,col) by streaming row of A and column of B through a complex MAC.
// ============================================================================
module complex_matrix_multiply
    import cmm_pkg::*;
#(
    parameter int MAX_DIM   = 16,
    parameter int ELEM_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    cmm_req_if.sink           req,
    cmm_rsp_if.source         rsp
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = $clog2(MAX_DIM);
    localparam int NW_MIN = $clog2(MAX_DIM + 1);
    localparam int NW     = (NW_MIN > SIZE_W) ? NW_MIN : SIZE_W;
    localparam int EW     = 2 * ELEM_BITS;

    logic [SIZE_W-1:0]        size_reg;
    state_t                   state_reg, state_next;
    logic [ROW_W-1:0]         row_reg, col_reg;
    logic                     range_reg;
    logic [IW-1:0]            s_reg;
    logic                     rd_vld_reg;
    logic [EW-1:0]            a_q_reg, b_q_reg;
    logic [EW-1:0]            mem_a [DEPTH];
    logic [EW-1:0]            mem_b [DEPTH];

    logic                     out_vld_reg;
    logic signed [SUM_W-1:0]  out_re_reg, out_im_reg;
    logic                     out_range_reg;

    mode_t                    req_mode;
    logic                     req_xfer;
    logic                     req_ok;
    logic [NW-1:0]            n_eff, n_m1;
    logic [IW-1:0]            last_idx;
    logic [AW-1:0]            wr_addr, a_raddr, b_raddr;
    logic                     wr_a, wr_b;
    logic                     issue, emit_load, mac_busy;
    mac_ctrl_t                mac_ctrl;
    logic signed [SUM_W-1:0]  sum_re, sum_im;

    // Effective size and range check
    always_comb
    begin
        n_eff    = (NW'(size_reg) > NW'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(size_reg);
        n_m1     = n_eff - NW'(1);
        last_idx = n_m1[IW-1:0];
        req_ok   = (NW'(req.row) < n_eff) && (NW'(req.col) < n_eff);
    end

    assign req_mode = mode_t'(req.mode);
    assign req_xfer = req.valid && req.ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && req_mode == MODE_RD)
                begin
                    state_next = req_ok ? ST_ISSUE : ST_EMIT;
                end
            end
            ST_ISSUE:
            begin
                if (s_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready    = (state_reg == ST_IDLE);
        issue        = (state_reg == ST_ISSUE);
        emit_load    = (state_reg == ST_EMIT) && (!out_vld_reg || rsp.ready);
        mac_ctrl.vld = rd_vld_reg;
        mac_ctrl.clr = req_xfer && (req_mode == MODE_RD);
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            s_reg      <= '0;
            rd_vld_reg <= 1'b0;
            range_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (mac_ctrl.clr)
            begin
                s_reg     <= '0;
                range_reg <= req_ok;
            end
            else if (issue)
            begin
                s_reg <= s_reg + IW'(1);
            end
        end
    end

    // Request latch for the read in progress
    always_ff @(posedge clk)
    begin
        if (mac_ctrl.clr)
        begin
            row_reg <= req.row;
            col_reg <= req.col;
        end
    end

    // Memory addresses: row-major, MAX_DIM entries per row
    always_comb
    begin
        wr_addr = AW'(req.row) * AW'(MAX_DIM) + AW'(req.col);
        a_raddr = AW'(row_reg) * AW'(MAX_DIM) + AW'(s_reg);
        b_raddr = AW'(s_reg) * AW'(MAX_DIM) + AW'(col_reg);
        wr_a    = req_xfer && req_ok && (req_mode == MODE_WR_A);
        wr_b    = req_xfer && req_ok && (req_mode == MODE_WR_B);
    end

    // Matrix memories with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= {req.im_in, req.re_in};
        end
        a_q_reg <= mem_a[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= {req.im_in, req.re_in};
        end
        b_q_reg <= mem_b[b_raddr];
    end

    // Complex multiply-accumulate
    cmm_mac #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_elem (a_q_reg),
        .b_elem (b_q_reg),
        .busy   (mac_busy),
        .sum_re (sum_re),
        .sum_im (sum_im)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_re_reg    <= sum_re;
            out_im_reg    <= sum_im;
            out_range_reg <= range_reg;
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.re_out   = out_re_reg;
    assign rsp.im_out   = out_im_reg;
    assign rsp.in_range = out_range_reg;

`ifndef SYNTHESIS
    // Counter never runs past the last term of the dot product
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (s_reg <= last_idx))
        else $error("term counter past last index");

    // Memory read data is only flagged valid after an issue cycle
    a_rd_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_ISSUE))
        else $error("read valid without issue");

    // Out-of-range responses carry a zero payload
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_range_reg) |-> (out_re_reg == '0 && out_im_reg == '0))
        else $error("out-of-range response not zero");

    // Leaving the emit state always leaves a response pending
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> out_vld_reg)
        else $error("emit without response");
`endif

endmodule

### dv/cmm_product_checker.sv
// ============================================================================
// cmm_product_checker: prediction and compare for complex_matrix_multiply
// Watches the size register, the request and the response channels. Keeps
// its own copy of both matrices and of the size, works out C(row,col) for
// every accepted product read, and checks each response in order.
// ============================================================================
module cmm_product_checker
    import cmm_pkg::*;
#(
    parameter int MAX_DIM = 16,
    parameter int ELEM_W  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    cmm_req_if                req_mon,
    cmm_rsp_if                rsp_mon,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
        logic                    in_range;
    } product_t;

    // Model copy of both matrices and of the size register
    logic signed [ELEM_W-1:0] a_re [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] a_im [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_re [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_im [MAX_DIM*MAX_DIM];
    logic [SIZE_W-1:0]        dim;
    product_t                 product_q[$];
    int                       errors;

    // Exact complex dot product of row r of A with column c of B
    function automatic product_t predict_product(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c);
        longint   sum_re;
        longint   sum_im;
        longint   ar, ai, br, bi;
        int       n;
        product_t p;
        n = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
        sum_re = 0;
        sum_im = 0;
        p.row = r;
        p.col = c;
        p.in_range = (r < n) && (c < n);
        if (p.in_range)
        begin
            for (int s = 0; s < n; s++)
            begin
                ar = a_re[r*MAX_DIM+s];
                ai = a_im[r*MAX_DIM+s];
                br = b_re[s*MAX_DIM+c];
                bi = b_im[s*MAX_DIM+c];
                sum_re += ar*br - ai*bi;
                sum_im += ar*bi + ai*br;
            end
        end
        p.re = sum_re[SUM_W-1:0];
        p.im = sum_im[SUM_W-1:0];
        return p;
    endfunction

    // Per-field compare, one line per wrong field
    task automatic report_field(string field, product_t p, longint exp_v, longint got_v);
        errors++;
        $display("%0t: C(%0d,%0d) %s mismatch: expected %0d, actual %0d",
                 $time, p.row, p.col, field, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_t p;
        int       n;
        if (!rst_n)
        begin
            dim = SIZE_RESET;
            product_q.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Size register write
            if (cfg_we)
                dim = cfg_wdata;

            // Request transfer: store an element or queue a product
            if (req_mon.valid && req_mon.ready)
            begin
                n = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
                case (mode_t'(req_mon.mode))
                    MODE_WR_A:
                        if (req_mon.row < n && req_mon.col < n)
                        begin
                            a_re[req_mon.row*MAX_DIM+req_mon.col] = req_mon.re_in;
                            a_im[req_mon.row*MAX_DIM+req_mon.col] = req_mon.im_in;
                        end
                    MODE_WR_B:
                        if (req_mon.row < n && req_mon.col < n)
                        begin
                            b_re[req_mon.row*MAX_DIM+req_mon.col] = req_mon.re_in;
                            b_im[req_mon.row*MAX_DIM+req_mon.col] = req_mon.im_in;
                        end
                    MODE_RD:
                        product_q.push_back(predict_product(req_mon.row, req_mon.col));
                    default: ;
                endcase
            end

            // Response transfer: compare with the oldest pending product
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (product_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: response with no read pending: expected none, actual %0d %0d %0b",
                             $time, rsp_mon.re_out, rsp_mon.im_out, rsp_mon.in_range);
                end
                else
                begin
                    p = product_q.pop_front();
                    if (rsp_mon.re_out !== p.re)
                        report_field("re_out", p, p.re, rsp_mon.re_out);
                    if (rsp_mon.im_out !== p.im)
                        report_field("im_out", p, p.im, rsp_mon.im_out);
                    if (rsp_mon.in_range !== p.in_range)
                        report_field("in_range", p, p.in_range, rsp_mon.in_range);
                end
            end

            fail_count  <= errors;
            outstanding <= product_q.size();
        end
    end

endmodule

### dv/tb_complex_matrix_multiply.sv
// ============================================================================
// tb_complex_matrix_multiply: stimulus and verdict for the matrix product
// Runs a short directed sequence, then phases at several matrix sizes that
// fill the matrices and mix element writes, product reads, out-of-range and
// unused requests, with random gaps and response stalls. The checker module
// predicts and compares; this module only drives and reports.
// ============================================================================
module tb_complex_matrix_multiply;
    import cmm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 16;
    localparam int ELEM_W  = 16;
    localparam int SETTLE  = 2*MAX_DIM + 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    int                fail_count;
    int                outstanding;

    cmm_req_if #(.ELEM_BITS(ELEM_W)) req_ch ();
    cmm_rsp_if                       rsp_ch ();

    complex_matrix_multiply #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    cmm_product_checker #(
        .MAX_DIM (MAX_DIM),
        .ELEM_W  (ELEM_W)
    ) product_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_mon     (req_ch),
        .rsp_mon     (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Which entries hold a written value, and the size now in use
    bit a_done [MAX_DIM*MAX_DIM];
    bit b_done [MAX_DIM*MAX_DIM];
    int cur_dim = SIZE_RESET;
    bit req_calm;
    bit rsp_calm;
    int n_writes, n_ignored, n_reads_in, n_reads_out, n_sizes;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Element part, biased toward the extremes
    function automatic logic signed [ELEM_W-1:0] pick_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return {1'b1, {(ELEM_W-1){1'b0}}};
        else if (r < 24)
            return {1'b0, {(ELEM_W-1){1'b1}}};
        else if (r < 30)
            return '0;
        else if (r < 36)
            return '1;
        return ELEM_W'($urandom);
    endfunction

    function automatic bit a_row_full(int r);
        for (int s = 0; s < cur_dim; s++)
            if (!a_done[r*MAX_DIM+s])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit b_col_full(int c);
        for (int s = 0; s < cur_dim; s++)
            if (!b_done[s*MAX_DIM+c])
                return 1'b0;
        return 1'b1;
    endfunction

    // Response side: random stalls, with calm stretches
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                rsp_calm = !rsp_calm;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!rsp_calm && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // One request transfer, after a random gap
    task automatic send_request(mode_t m, int r, int c,
                                logic signed [ELEM_W-1:0] re_part,
                                logic signed [ELEM_W-1:0] im_part);
        int  gap;
        bit  hit;
        gap = req_calm ? 0 : pick_gap();
        if ($urandom_range(0, 59) == 0)
            req_calm = !req_calm;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= m;
        req_ch.row   <= ROW_W'(r);
        req_ch.col   <= ROW_W'(c);
        req_ch.re_in <= re_part;
        req_ch.im_in <= im_part;
        do @(posedge clk); while (!req_ch.ready);

        hit = (r < cur_dim) && (c < cur_dim);
        case (m)
            MODE_WR_A, MODE_WR_B:
                if (hit)
                begin
                    n_writes++;
                    if (m == MODE_WR_A)
                        a_done[r*MAX_DIM+c] = 1'b1;
                    else
                        b_done[r*MAX_DIM+c] = 1'b1;
                end
                else
                    n_ignored++;
            MODE_RD:
                if (hit)
                    n_reads_in++;
                else
                    n_reads_out++;
            default:
                n_ignored++;
        endcase
    endtask

    // Size change, only once the block has gone quiet
    task automatic set_size(int n);
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= SIZE_W'(n);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_dim = n;
        n_sizes++;
    endtask

    // Mixed traffic: writes, reads of fully written products, noise
    task automatic random_request();
        int pick, r, c;
        int ok_rows[$];
        int ok_cols[$];
        pick = $urandom_range(0, 99);
        for (int i = 0; i < cur_dim; i++)
        begin
            if (a_row_full(i))
                ok_rows.push_back(i);
            if (b_col_full(i))
                ok_cols.push_back(i);
        end
        // Nothing lies out of range at full size
        if (cur_dim == MAX_DIM && pick >= 40 && pick < 48)
            pick = 0;
        if (cur_dim == MAX_DIM && pick >= 80 && pick < 92)
            pick = 50;
        if (pick >= 48 && pick < 80 && (ok_rows.size() == 0 || ok_cols.size() == 0))
            pick = 0;

        if (pick < 48)
        begin
            r = $urandom_range(0, cur_dim - 1);
            c = $urandom_range(0, cur_dim - 1);
            if (pick >= 40)
            begin
                case ($urandom_range(0, 2))
                    0: r = $urandom_range(cur_dim, MAX_DIM - 1);
                    1: c = $urandom_range(cur_dim, MAX_DIM - 1);
                    default:
                    begin
                        r = $urandom_range(cur_dim, MAX_DIM - 1);
                        c = $urandom_range(cur_dim, MAX_DIM - 1);
                    end
                endcase
            end
            send_request($urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A, r, c,
                         pick_part(), pick_part());
        end
        else if (pick < 80)
        begin
            r = ok_rows[$urandom_range(0, ok_rows.size() - 1)];
            c = ok_cols[$urandom_range(0, ok_cols.size() - 1)];
            send_request(MODE_RD, r, c, ELEM_W'($urandom), ELEM_W'($urandom));
        end
        else if (pick < 92)
        begin
            r = $urandom_range(0, MAX_DIM - 1);
            c = $urandom_range(cur_dim, MAX_DIM - 1);
            if ($urandom_range(0, 1))
                send_request(MODE_RD, c, r, ELEM_W'($urandom), ELEM_W'($urandom));
            else
                send_request(MODE_RD, r, c, ELEM_W'($urandom), ELEM_W'($urandom));
        end
        else
            send_request(MODE_NOP, $urandom_range(0, MAX_DIM - 1),
                         $urandom_range(0, MAX_DIM - 1), pick_part(), pick_part());
    endtask

    // One size setting: fill what is still unwritten, then mixed traffic
    task automatic run_phase(int n, int mix_items);
        set_size(n);
        for (int r = 0; r < n; r++)
        begin
            for (int s = 0; s < n; s++)
            begin
                while ($urandom_range(0, 99) < 15)
                    random_request();
                if (!a_done[r*MAX_DIM+s])
                    send_request(MODE_WR_A, r, s, pick_part(), pick_part());
                if (!b_done[s*MAX_DIM+r])
                    send_request(MODE_WR_B, s, r, pick_part(), pick_part());
            end
        end
        repeat (mix_items) random_request();
    endtask

    // Stimulus
    initial
    begin
        logic signed [ELEM_W-1:0] pmax;
        logic signed [ELEM_W-1:0] pmin;
        pmax = {1'b0, {(ELEM_W-1){1'b1}}};
        pmin = {1'b1, {(ELEM_W-1){1'b0}}};
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_NOP;
        req_ch.row    <= '0;
        req_ch.col    <= '0;
        req_ch.re_in  <= '0;
        req_ch.im_in  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner entries at the reset size; they must stick for later reads
        send_request(MODE_WR_A, MAX_DIM - 1, MAX_DIM - 1, pmin, pmax);
        send_request(MODE_WR_B, MAX_DIM - 1, MAX_DIM - 1, pmax, pmin);
        send_request(MODE_NOP, MAX_DIM - 1, MAX_DIM - 1, pmax, pmin);

        // 2x2: extreme products, ignored writes, out-of-range reads
        set_size(2);
        send_request(MODE_WR_A, 0, 0, pmax, pmax);
        send_request(MODE_WR_A, 0, 1, pmin, pmin);
        send_request(MODE_WR_B, 0, 0, pmin, pmax);
        send_request(MODE_WR_B, 1, 0, pmin, pmin);
        send_request(MODE_RD, 0, 0, '0, '0);
        send_request(MODE_WR_A, 2, 0, pmax, pmax);
        send_request(MODE_WR_B, 0, 2, pmin, pmin);
        send_request(MODE_RD, 2, 0, pmax, pmax);
        send_request(MODE_RD, 0, 2, '1, '1);
        send_request(MODE_RD, MAX_DIM - 1, MAX_DIM - 1, pmin, pmin);
        send_request(MODE_WR_A, 1, 0, pmin, pmax);
        send_request(MODE_WR_A, 1, 1, pmin, pmin);
        send_request(MODE_WR_B, 0, 1, pmin, pmin);
        send_request(MODE_WR_B, 1, 1, pmax, pmin);
        send_request(MODE_RD, 0, 1, '0, '0);
        send_request(MODE_RD, 1, 0, '0, '0);
        send_request(MODE_RD, 1, 1, '0, '0);
        send_request(MODE_NOP, 0, 0, pmax, pmax);

        // Growing sizes fill the matrices, later ones reuse what is there
        run_phase(1, 60);
        run_phase(5, 60);
        run_phase(MAX_DIM, 60);
        run_phase(MAX_DIM, 70);
        run_phase(1, 70);
        run_phase(9, 70);
        run_phase(2, 70);
        run_phase(13, 70);
        run_phase($urandom_range(1, MAX_DIM), 70);

        // Drain
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d element writes, %0d in-range and %0d out-of-range product reads,",
                 n_writes, n_reads_in, n_reads_out);
        $display("%0d ignored requests, over %0d size settings from 1 to %0d.",
                 n_ignored, n_sizes, MAX_DIM);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/cmm_pkg.sv
rtl/cmm_if.sv
rtl/cmm_mac.sv
rtl/complex_matrix_multiply.sv
dv/cmm_product_checker.sv
dv/tb_complex_matrix_multiply.sv
